/* sv/twd_pkg.sv */
package twd_pkg;

  // Pool and alphabet sizing
  localparam int NODE_COUNT = 1024;
  localparam int ALPHABET   = 26;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int USED_W   = $clog2(NODE_COUNT + 1);
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int LETTER_W = 5;
  localparam int NIU_W    = 11;

  // One memory row per node: ALPHABET child links, then the word-end mark
  localparam int ROW_W   = ALPHABET * NODE_W + 1;
  localparam int END_BIT = ROW_W - 1;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  // Clamp a letter code to the last symbol of the alphabet
  function automatic sym_t sat_sym(logic [LETTER_W-1:0] letter);
    sym_t res;
    if (int'(letter) >= ALPHABET) begin
      res = SYM_W'(ALPHABET - 1);
    end else begin
      res = SYM_W'(letter);
    end
    return res;
  endfunction

endpackage

/* sv/trie_word_dictionary.sv */
// Trie word dictionary: a word streams in one letter per transaction (tdata holds the letter,
// tuser[0] is the op, 0 insert / 1 search, tuser[1] marks a transaction with no letter, and
// tlast marks the final letter); the transaction that ends a word yields one result with
// found, pool_full and the number of pool nodes in use. Each node is one row of a single
// synchronous memory (every child link plus the word-end mark), so every transaction costs
// one row read before its work can start (accept and read, then walk), and a final item
// that carries a letter needs a second row read for the word-end mark of the node it reaches.
// A result sits in an output register, so the next word can start while it waits. There is
// no clearing pass after reset: only the node the walk stands on can be unwritten (the root
// after reset, or the node just taken from the pool); its row reads as empty and is written
// in full when the walk leaves it or the word ends.
module trie_word_dictionary (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side: tdata = letter[4:0], zero pad; tuser = op[0], no_letter[1]; tlast = last
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [twd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [twd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  logic                              s_axis_tlast,
  // master side: tdata = found[0], pool_full[1], nodes_in_use[12:2], zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [twd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // Node pool: one row per node
  twd_pkg::row_t   mem_q [twd_pkg::NODE_COUNT];
  twd_pkg::row_t   rd_row_q;

  twd_pkg::state_e state_q, state_d;

  // Transaction held during its walk
  logic            op_q, last_q, nol_q;
  twd_pkg::sym_t   sym_q;

  // Walk state
  twd_pkg::node_t  cursor_q, cursor_d;
  twd_pkg::used_t  used_q, used_d;
  logic            fresh_q, fresh_d;
  logic            missed_q, missed_d;
  logic            ovf_q, ovf_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic            out_found_q, out_found_d;
  logic            out_full_q, out_full_d;
  twd_pkg::used_t  out_used_q, out_used_d;

  // Memory ports
  logic            rd_en, wr_en;
  twd_pkg::node_t  rd_addr, wr_addr;
  twd_pkg::row_t   wr_row;

  logic            accept, out_free;
  twd_pkg::row_t   row_eff, link_row, fin_row;
  twd_pkg::node_t  link;
  logic            walk_go, alloc, mark;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == twd_pkg::ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(twd_pkg::OUT_TDATA_W - twd_pkg::NIU_W - 2)'(0),
                          twd_pkg::NIU_W'(out_used_q), out_full_q, out_found_q};

  // Row of the node under the cursor; an unwritten row reads as empty
  assign row_eff = fresh_q ? '0 : rd_row_q;
  assign fin_row = row_eff;

  // Pick the child link and build the row with a fresh link in that slot
  always_comb begin
    link     = '0;
    link_row = row_eff;
    for (int s = 0; s < twd_pkg::ALPHABET; s++) begin
      if (sym_q == twd_pkg::SYM_W'(s)) begin
        link = row_eff[s*twd_pkg::NODE_W +: twd_pkg::NODE_W];
        link_row[s*twd_pkg::NODE_W +: twd_pkg::NODE_W] = twd_pkg::NODE_W'(used_q);
      end
    end
  end

  assign walk_go = !nol_q && !missed_q && !ovf_q;
  assign alloc   = walk_go && (link == '0) && !op_q
                && (used_q < twd_pkg::USED_W'(twd_pkg::NODE_COUNT));
  // An insert that neither missed nor overflowed marks its final node
  assign mark    = !op_q && !missed_q && !ovf_q;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    used_d      = used_q;
    fresh_d     = fresh_q;
    missed_d    = missed_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    out_used_d  = out_used_q;
    rd_en       = 1'b0;
    rd_addr     = cursor_q;
    wr_en       = 1'b0;
    wr_addr     = cursor_q;
    wr_row      = link_row;

    case (state_q)
      twd_pkg::ST_IDLE: begin
        // Fetch the cursor row for the accepted transaction
        if (accept) begin
          rd_en   = 1'b1;
          state_d = twd_pkg::ST_WALK;
        end
      end
      twd_pkg::ST_WALK: begin
        if (nol_q) begin
          // No letter: the row just read already is the final node
          if (out_free) begin
            state_d = twd_pkg::ST_IDLE;
          end
        end else begin
          if (walk_go) begin
            if (link != '0) begin
              cursor_d = link;
              fresh_d  = 1'b0;
            end else if (op_q) begin
              missed_d = 1'b1;
            end else if (alloc) begin
              // Write back the parent row with the new link, step onto the new node
              wr_en    = 1'b1;
              cursor_d = twd_pkg::NODE_W'(used_q);
              used_d   = used_q + twd_pkg::USED_W'(1);
              fresh_d  = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (last_q) begin
            // Read the reached node for its word-end mark
            rd_en   = 1'b1;
            rd_addr = cursor_d;
            state_d = twd_pkg::ST_FIN;
          end else begin
            state_d = twd_pkg::ST_IDLE;
          end
        end
      end
      twd_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = twd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = twd_pkg::ST_IDLE;
      end
    endcase

    // Finish the word: deliver the result, settle the final row, return to the root
    if ((state_q == twd_pkg::ST_FIN || (state_q == twd_pkg::ST_WALK && nol_q)) && out_free) begin
      wr_en       = fresh_q || mark;
      wr_addr     = cursor_q;
      wr_row      = fin_row;
      if (mark) begin
        wr_row[twd_pkg::END_BIT] = 1'b1;
      end
      out_valid_d = 1'b1;
      out_found_d = op_q && !missed_q && !ovf_q && fin_row[twd_pkg::END_BIT];
      out_full_d  = !op_q && ovf_q;
      out_used_d  = used_q;
      cursor_d    = '0;
      fresh_d     = 1'b0;
      missed_d    = 1'b0;
      ovf_d       = 1'b0;
    end
  end

  // Node pool memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[rd_addr];
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser[0];
      nol_q  <= s_axis_tuser[1];
      last_q <= s_axis_tlast;
      sym_q  <= twd_pkg::sat_sym(s_axis_tdata[twd_pkg::LETTER_W-1:0]);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
    out_used_q  <= out_used_d;
  end

  // Control state; the root starts out unwritten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twd_pkg::ST_IDLE;
      cursor_q    <= '0;
      used_q      <= twd_pkg::USED_W'(1);
      fresh_q     <= 1'b1;
      missed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      used_q      <= used_d;
      fresh_q     <= fresh_d;
      missed_q    <= missed_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pool count stays between one and the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q >= twd_pkg::USED_W'(1) && used_q <= twd_pkg::USED_W'(twd_pkg::NODE_COUNT))
    else $error("node count out of range");

  // The cursor always stands on an allocated node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    twd_pkg::USED_W'(cursor_q) < used_q)
    else $error("cursor beyond allocated nodes");

  // Only the newest node can be unwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q |-> (twd_pkg::USED_W'(cursor_q) + twd_pkg::USED_W'(1) == used_q))
    else $error("unwritten node is not the newest");

  // A walk stops for one reason only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(missed_q && ovf_q))
    else $error("miss and overflow both set");

  // No row is written while waiting for a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twd_pkg::ST_IDLE) |-> !wr_en)
    else $error("memory write while idle");

endmodule
